@@ sv/stl_pkg.sv @@
// Shared types, codes and lookup functions for the source code token lexer.
package stl_pkg;

   localparam int MAX_KEYWORD_LEN = 6;
   localparam int WORD_W = 8 * MAX_KEYWORD_LEN;
   localparam int LEN_W = $clog2(MAX_KEYWORD_LEN + 2);
   localparam int TOK_W = 5;
   localparam int NSLOT = 4;
   localparam int SLOT_W = $clog2(NSLOT);
   localparam int Q_DEPTH = 4;
   localparam int PTR_W = $clog2(Q_DEPTH);
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [TOK_W-1:0] TOK_TYPE   = 5'd0;
   localparam logic [TOK_W-1:0] TOK_FOR    = 5'd1;
   localparam logic [TOK_W-1:0] TOK_WHILE  = 5'd2;
   localparam logic [TOK_W-1:0] TOK_IF     = 5'd3;
   localparam logic [TOK_W-1:0] TOK_ELSE   = 5'd4;
   localparam logic [TOK_W-1:0] TOK_RETURN = 5'd5;
   localparam logic [TOK_W-1:0] TOK_DEF    = 5'd6;
   localparam logic [TOK_W-1:0] TOK_LOGIC  = 5'd7;
   localparam logic [TOK_W-1:0] TOK_CONST  = 5'd8;
   localparam logic [TOK_W-1:0] TOK_BOOL   = 5'd9;
   localparam logic [TOK_W-1:0] TOK_ID     = 5'd10;
   localparam logic [TOK_W-1:0] TOK_NUM    = 5'd11;
   localparam logic [TOK_W-1:0] TOK_EQ     = 5'd12;
   localparam logic [TOK_W-1:0] TOK_ASSIGN = 5'd13;
   localparam logic [TOK_W-1:0] TOK_INC    = 5'd14;
   localparam logic [TOK_W-1:0] TOK_PLUS   = 5'd15;
   localparam logic [TOK_W-1:0] TOK_DEC    = 5'd16;
   localparam logic [TOK_W-1:0] TOK_MINUS  = 5'd17;
   localparam logic [TOK_W-1:0] TOK_LTE    = 5'd18;
   localparam logic [TOK_W-1:0] TOK_LT     = 5'd19;
   localparam logic [TOK_W-1:0] TOK_GTE    = 5'd20;
   localparam logic [TOK_W-1:0] TOK_GT     = 5'd21;
   localparam logic [TOK_W-1:0] TOK_DOT    = 5'd22;
   localparam logic [TOK_W-1:0] TOK_LBR    = 5'd23;
   localparam logic [TOK_W-1:0] TOK_RBR    = 5'd24;
   localparam logic [TOK_W-1:0] TOK_NEQ    = 5'd25;
   localparam logic [TOK_W-1:0] TOK_NOT    = 5'd26;
   localparam logic [TOK_W-1:0] TOK_RAW    = 5'd27;
   localparam logic [TOK_W-1:0] TOK_END    = 5'd28;

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_WORD = 2'd1;
   localparam logic [1:0] MODE_NUM  = 2'd2;
   localparam logic [1:0] MODE_OP   = 2'd3;

   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_EQ    = 3'd1;
   localparam logic [2:0] OP_PLUS  = 3'd2;
   localparam logic [2:0] OP_MINUS = 3'd3;
   localparam logic [2:0] OP_LT    = 3'd4;
   localparam logic [2:0] OP_GT    = 3'd5;
   localparam logic [2:0] OP_BANG  = 3'd6;

   typedef struct packed {
      logic [NSLOT-1:0]            mask;
      logic [NSLOT-1:0][TOK_W-1:0] tok;
      logic [7:0]                  raw;
   } entry_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c inside {["a":"z"], ["A":"Z"]});
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c inside {["0":"9"]});
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == "_");
   endfunction

   function automatic logic is_dropped(input logic [7:0] c);
      return (c inside {8'd32, [8'd9:8'd13], "(", ")", "{", "}", ";", ","});
   endfunction

   function automatic logic [2:0] op_code(input logic [7:0] c);
      logic [2:0] r;
      case (c)
         "=":     r = OP_EQ;
         "+":     r = OP_PLUS;
         "-":     r = OP_MINUS;
         "<":     r = OP_LT;
         ">":     r = OP_GT;
         "!":     r = OP_BANG;
         default: r = OP_NONE;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] op_second(input logic [2:0] op);
      logic [7:0] r;
      case (op)
         OP_PLUS:  r = "+";
         OP_MINUS: r = "-";
         OP_EQ, OP_LT, OP_GT, OP_BANG: r = "=";
         default:  r = 8'd0;
      endcase
      return r;
   endfunction

   function automatic logic [TOK_W-1:0] op_double(input logic [2:0] op);
      logic [TOK_W-1:0] r;
      case (op)
         OP_EQ:    r = TOK_EQ;
         OP_PLUS:  r = TOK_INC;
         OP_MINUS: r = TOK_DEC;
         OP_LT:    r = TOK_LTE;
         OP_GT:    r = TOK_GTE;
         OP_BANG:  r = TOK_NEQ;
         default:  r = TOK_ID;
      endcase
      return r;
   endfunction

   function automatic logic [TOK_W-1:0] op_single(input logic [2:0] op);
      logic [TOK_W-1:0] r;
      case (op)
         OP_EQ:    r = TOK_ASSIGN;
         OP_PLUS:  r = TOK_PLUS;
         OP_MINUS: r = TOK_MINUS;
         OP_LT:    r = TOK_LT;
         OP_GT:    r = TOK_GT;
         OP_BANG:  r = TOK_NOT;
         default:  r = TOK_ID;
      endcase
      return r;
   endfunction

   // Word bytes are right aligned, first byte highest; unused leading bytes are zero.
   function automatic logic [TOK_W-1:0] kw_lookup(input logic [WORD_W-1:0] word,
                                                  input logic [LEN_W-1:0] len);
      logic [TOK_W-1:0] r;
      if (len > LEN_W'(MAX_KEYWORD_LEN)) begin
         r = TOK_ID;
      end else begin
         case (word)
            WORD_W'("int"), WORD_W'("float"), WORD_W'("double"), WORD_W'("char"),
            WORD_W'("void"), WORD_W'("long"), WORD_W'("bool"), WORD_W'("string"),
            WORD_W'("vector"), WORD_W'("map"), WORD_W'("set"), WORD_W'("list"),
            WORD_W'("dict"), WORD_W'("tuple"): r = TOK_TYPE;
            WORD_W'("for"):    r = TOK_FOR;
            WORD_W'("while"):  r = TOK_WHILE;
            WORD_W'("if"):     r = TOK_IF;
            WORD_W'("else"), WORD_W'("elif"): r = TOK_ELSE;
            WORD_W'("return"): r = TOK_RETURN;
            WORD_W'("def"), WORD_W'("class"): r = TOK_DEF;
            WORD_W'("and"), WORD_W'("or"), WORD_W'("not"): r = TOK_LOGIC;
            WORD_W'("const"):  r = TOK_CONST;
            WORD_W'("true"), WORD_W'("false"), WORD_W'("True"), WORD_W'("False"):
               r = TOK_BOOL;
            default:           r = TOK_ID;
         endcase
      end
      return r;
   endfunction

endpackage

@@ sv/stl_front.sv @@
// Front end: accepts bytes, tracks lexer state and builds the token group of each byte.
module stl_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_ch,
   input  logic                req_end_of_text,
   input  logic                q_full,
   output logic                push_valid,
   output stl_pkg::entry_type  push_entry
);
   import stl_pkg::*;

   logic [1:0]        mode_ff, mode_in;
   logic [2:0]        op_ff, op_in;
   logic [WORD_W-1:0] buf_ff, buf_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              consumed;
   logic              xfer;
   entry_type         ent;

   assign req_ready = !q_full;
   assign xfer = req_valid && req_ready;

   always_comb begin
      mode_in = mode_ff;
      op_in = op_ff;
      buf_in = buf_ff;
      len_in = len_ff;
      consumed = 1'b0;
      ent = '0;

      case (mode_ff)
         MODE_OP: begin
            if (op_ff != OP_NONE && req_ch == op_second(op_ff)) begin
               ent.mask[0] = 1'b1;
               ent.tok[0] = op_double(op_ff);
               consumed = 1'b1;
            end else if (op_ff != OP_NONE) begin
               ent.mask[0] = 1'b1;
               ent.tok[0] = op_single(op_ff);
            end
            mode_in = MODE_IDLE;
            op_in = OP_NONE;
         end
         MODE_WORD: begin
            if (is_word_char(req_ch)) begin
               if (len_ff < LEN_W'(MAX_KEYWORD_LEN)) begin
                  buf_in = {buf_ff[WORD_W-9:0], req_ch};
                  len_in = len_ff + LEN_W'(1);
               end else begin
                  len_in = LEN_W'(MAX_KEYWORD_LEN + 1);
               end
               consumed = 1'b1;
            end else begin
               ent.mask[0] = 1'b1;
               ent.tok[0] = kw_lookup(buf_ff, len_ff);
               mode_in = MODE_IDLE;
               op_in = OP_NONE;
               buf_in = '0;
               len_in = '0;
            end
         end
         MODE_NUM: begin
            if (is_digit(req_ch) || req_ch == ".") begin
               consumed = 1'b1;
            end else begin
               ent.mask[0] = 1'b1;
               ent.tok[0] = TOK_NUM;
               mode_in = MODE_IDLE;
               op_in = OP_NONE;
               buf_in = '0;
               len_in = '0;
            end
         end
         default: begin
         end
      endcase

      if (!consumed && !is_dropped(req_ch)) begin
         if (is_alpha(req_ch) || req_ch == "_") begin
            mode_in = MODE_WORD;
            buf_in = WORD_W'(req_ch);
            len_in = LEN_W'(1);
         end else if (is_digit(req_ch)) begin
            mode_in = MODE_NUM;
         end else if (op_code(req_ch) != OP_NONE) begin
            mode_in = MODE_OP;
            op_in = op_code(req_ch);
         end else begin
            ent.mask[1] = 1'b1;
            case (req_ch)
               ".":     ent.tok[1] = TOK_DOT;
               "[":     ent.tok[1] = TOK_LBR;
               "]":     ent.tok[1] = TOK_RBR;
               default: begin
                  ent.tok[1] = TOK_RAW;
                  ent.raw = req_ch;
               end
            endcase
         end
      end

      if (req_end_of_text) begin
         case (mode_in)
            MODE_WORD: begin
               ent.mask[2] = 1'b1;
               ent.tok[2] = kw_lookup(buf_in, len_in);
            end
            MODE_NUM: begin
               ent.mask[2] = 1'b1;
               ent.tok[2] = TOK_NUM;
            end
            MODE_OP: begin
               ent.mask[2] = (op_in != OP_NONE);
               ent.tok[2] = op_single(op_in);
            end
            default: begin
            end
         endcase
         ent.mask[3] = 1'b1;
         ent.tok[3] = TOK_END;
         mode_in = MODE_IDLE;
         op_in = OP_NONE;
         buf_in = '0;
         len_in = '0;
      end
   end

   assign push_valid = xfer && (ent.mask != '0);
   assign push_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         op_ff <= OP_NONE;
         buf_ff <= '0;
         len_ff <= '0;
      end else if (xfer) begin
         mode_ff <= mode_in;
         op_ff <= op_in;
         buf_ff <= buf_in;
         len_ff <= len_in;
      end
   end

endmodule

@@ sv/stl_queue.sv @@
// Small queue of token groups between the front end and the output serializer.
module stl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stl_pkg::entry_type  push_entry,
   input  logic                pop,
   output stl_pkg::entry_type  head,
   output logic                empty,
   output logic                full
);
   import stl_pkg::*;

   entry_type         mem_ff [Q_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign empty = (count_ff == '0);
   assign full = (count_ff == CNT_W'(Q_DEPTH));
   assign head = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue push while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue pop while empty");
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[PTR_W-1:0])
      else $error("queue count disagrees with pointers");
   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      push |=> !empty)
      else $error("queue empty after push");

endmodule

@@ sv/stl_back.sv @@
// Back end: sends the tokens of the head group one per transfer and marks the last one.
module stl_back (
   input  logic                    clock,
   input  logic                    reset,
   input  stl_pkg::entry_type      head,
   input  logic                    empty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [stl_pkg::TOK_W-1:0] rsp_token,
   output logic [7:0]              rsp_raw_char,
   output logic                    rsp_last
);
   import stl_pkg::*;

   logic [NSLOT-1:0]  sent_ff, sent_in;
   logic [NSLOT-1:0]  remaining;
   logic [NSLOT-1:0]  sel_hot;
   logic [SLOT_W-1:0] sel;
   logic              xfer;

   assign remaining = head.mask & ~sent_ff;

   always_comb begin
      sel = '0;
      for (int i = NSLOT - 1; i >= 0; i--) begin
         if (remaining[i]) begin
            sel = SLOT_W'(i);
         end
      end
   end

   assign sel_hot = NSLOT'(1) << sel;
   assign rsp_valid = !empty;
   assign rsp_token = head.tok[sel];
   assign rsp_raw_char = (head.tok[sel] == TOK_RAW) ? head.raw : 8'd0;
   assign rsp_last = ((remaining & ~sel_hot) == '0);
   assign xfer = rsp_valid && rsp_ready;
   assign pop = xfer && rsp_last;
   assign sent_in = pop ? '0 : (sent_ff | sel_hot);

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff <= '0;
      end else if (xfer) begin
         sent_ff <= sent_in;
      end
   end

   a_head_has_token: assert property (@(posedge clock) disable iff (reset)
      !empty |-> remaining != '0)
      else $error("head group has no token left to send");
   a_hold_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token)
         && $stable(rsp_raw_char) && $stable(rsp_last))
      else $error("result changed while waiting");
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      pop |-> rsp_valid && rsp_last)
      else $error("group popped before its last token");

endmodule

@@ sv/source_code_token_lexer_core.sv @@
// Source code token lexer: one byte of text in, normalized token codes out.
// Input channel req_*: one byte (req_ch) per transfer; req_end_of_text marks
// the final byte, which flushes any pending word, number or operator and
// appends an END token.
// Result channel rsp_*: one token per transfer; rsp_raw_char carries the byte
// for raw tokens and is zero otherwise; rsp_last flags the final token caused
// by one input byte. A byte may cause no tokens (whitespace, dropped
// punctuation, a byte that extends a word or number).
// A byte is classified in the cycle it is taken; its tokens can appear on
// rsp_* the next cycle. Throughput is one byte per cycle as long as each byte
// yields at most one token; a byte with n tokens occupies the result channel
// for n transfers. A four-entry queue of token groups sits between the
// front end and the serializer, so bytes keep flowing while the receiver
// stalls until the queue fills, at which point req_ready drops.
// Synchronous reset returns the lexer to idle, with no pending word or
// operator, and empties the queue.
module source_code_token_lexer_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_ch,
   input  logic                      req_end_of_text,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [stl_pkg::TOK_W-1:0] rsp_token,
   output logic [7:0]                rsp_raw_char,
   output logic                      rsp_last
);
   import stl_pkg::*;

   entry_type push_entry;
   entry_type head;
   logic      push_valid;
   logic      pop;
   logic      empty;
   logic      full;

   stl_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_end_of_text (req_end_of_text),
      .q_full          (full),
      .push_valid      (push_valid),
      .push_entry      (push_entry)
   );

   stl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   stl_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .empty        (empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_token    (rsp_token),
      .rsp_raw_char (rsp_raw_char),
      .rsp_last     (rsp_last)
   );

endmodule
